/* src/sawcr_pkg.sv */
package sawcr_pkg;

  // Register map (index = paddr[4:2])
  localparam int unsigned AddrWidth = 5;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrWidth = $clog2(QueueDepth);
  localparam int unsigned QueueCntWidth = $clog2(QueueDepth + 1);

  typedef enum logic [2:0] {
    REG_TIMEOUT_LIMIT   = 3'd0,
    REG_FILE_IDENT      = 3'd1,
    REG_INFO_MESSAGE_ID = 3'd2,
    REG_CHUNK_PACKET_ID = 3'd3,
    REG_END_MESSAGE_ID  = 3'd4,
    REG_INFO_MIN_LENGTH = 3'd5,
    REG_MAX_CHUNK_BYTES = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_MESSAGE = 2'd1,
    KIND_CHUNK   = 2'd2,
    KIND_OTHER   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_INFO     = 3'd1,
    PH_CHUNK    = 3'd2,
    PH_ACK      = 3'd3,
    PH_COMPLETE = 3'd4,
    PH_ERROR    = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    RQ_NONE  = 3'd0,
    RQ_CLEAR = 3'd1,
    RQ_OPEN  = 3'd2,
    RQ_WRITE = 3'd3,
    RQ_META  = 3'd4,
    RQ_CLOSE = 3'd5
  } req_t;

  typedef struct packed {
    logic [15:0] timeout_limit;
    logic [7:0]  file_ident;
    logic [7:0]  info_message_id;
    logic [7:0]  chunk_packet_id;
    logic [7:0]  end_message_id;
    logic [7:0]  info_min_length;
    logic [7:0]  max_chunk_bytes;
  } cfg_t;

  // Classified poll item, as queued between front and back
  typedef struct packed {
    logic        info_ok;
    logic        chunk_ok;
    logic        end_ok;
    logic [7:0]  msg_length;
    logic [31:0] word_one;
    logic [31:0] word_two;
    logic [15:0] packet_index;
    logic        storage_ok;
  } item_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [2:0]  request;
    logic [15:0] chunk_index;
    logic [7:0]  chunk_length;
    logic        send_ack;
    logic        transfer_done;
    logic        went_error;
    logic [31:0] chunk_size_out;
    logic [16:0] received_count;
    logic [31:0] expected_total;
  } result_t;

endpackage

/* src/sawcr_if.sv */
interface sawcr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  msg_id;
  logic [7:0]  msg_length;
  logic [7:0]  first_byte;
  logic [31:0] word_one;
  logic [31:0] word_two;
  logic [15:0] packet_index;
  logic        storage_ok;

  modport source(
    output valid, kind, msg_id, msg_length, first_byte, word_one, word_two,
           packet_index, storage_ok,
    input  ready
  );
  modport sink(
    input  valid, kind, msg_id, msg_length, first_byte, word_one, word_two,
           packet_index, storage_ok,
    output ready
  );
endinterface

interface sawcr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  phase;
  logic [2:0]  request;
  logic [15:0] chunk_index;
  logic [7:0]  chunk_length;
  logic        send_ack;
  logic        transfer_done;
  logic        went_error;
  logic [31:0] chunk_size_out;
  logic [16:0] received_count;
  logic [31:0] expected_total;

  modport source(
    output valid, phase, request, chunk_index, chunk_length, send_ack,
           transfer_done, went_error, chunk_size_out, received_count,
           expected_total,
    input  ready
  );
  modport sink(
    input  valid, phase, request, chunk_index, chunk_length, send_ack,
           transfer_done, went_error, chunk_size_out, received_count,
           expected_total,
    output ready
  );
endinterface

/* src/stop_and_wait_chunk_receiver.sv */
// An accepted poll is queued; the back then pops it and registers its result.
// Throughput: one poll per cycle while results drain; a two-entry queue parts
// the classifying front from the state machine, and the result register lets the
// back stall on its own. Reset (rst_n, synchronous, active low) empties the queue,
// drops the result, returns to the idle phase and loads the register reset values.
module stop_and_wait_chunk_receiver (
  input  logic                            clk,
  input  logic                            rst_n,
  sawcr_in_if.sink                        in_ch,
  sawcr_out_if.source                     out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sawcr_pkg::AddrWidth-1:0] paddr,
  input  logic [sawcr_pkg::DataWidth-1:0] pwdata,
  output logic [sawcr_pkg::DataWidth-1:0] prdata,
  output logic                            pready
);
  import sawcr_pkg::*;

  cfg_t    cfg;
  item_t   push_item;
  item_t   head_item;
  logic    q_push, q_not_full, q_pop, q_not_empty;
  result_t res;

  sawcr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sawcr_front u_front (
    .in_ch   (in_ch),
    .cfg     (cfg),
    .q_ready (q_not_full),
    .q_push  (q_push),
    .q_item  (push_item)
  );

  sawcr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .head_item (head_item),
    .not_empty (q_not_empty)
  );

  sawcr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .head_item  (head_item),
    .head_valid (q_not_empty),
    .pop        (q_pop),
    .res        (res),
    .res_valid  (out_ch.valid),
    .res_ready  (out_ch.ready)
  );

  // Drive result payload
  assign out_ch.phase          = res.phase;
  assign out_ch.request        = res.request;
  assign out_ch.chunk_index    = res.chunk_index;
  assign out_ch.chunk_length   = res.chunk_length;
  assign out_ch.send_ack       = res.send_ack;
  assign out_ch.transfer_done  = res.transfer_done;
  assign out_ch.went_error     = res.went_error;
  assign out_ch.chunk_size_out = res.chunk_size_out;
  assign out_ch.received_count = res.received_count;
  assign out_ch.expected_total = res.expected_total;

endmodule

/* src/sawcr_regs.sv */
module sawcr_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sawcr_pkg::AddrWidth-1:0] paddr,
  input  logic [sawcr_pkg::DataWidth-1:0] pwdata,
  output logic [sawcr_pkg::DataWidth-1:0] prdata,
  output logic                           pready,
  output sawcr_pkg::cfg_t                cfg
);
  import sawcr_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[AddrWidth-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  // Decode write
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_TIMEOUT_LIMIT:   cfg_nxt.timeout_limit   = pwdata[15:0];
        REG_FILE_IDENT:      cfg_nxt.file_ident      = pwdata[7:0];
        REG_INFO_MESSAGE_ID: cfg_nxt.info_message_id = pwdata[7:0];
        REG_CHUNK_PACKET_ID: cfg_nxt.chunk_packet_id = pwdata[7:0];
        REG_END_MESSAGE_ID:  cfg_nxt.end_message_id  = pwdata[7:0];
        REG_INFO_MIN_LENGTH: cfg_nxt.info_min_length = pwdata[7:0];
        REG_MAX_CHUNK_BYTES: cfg_nxt.max_chunk_bytes = pwdata[7:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_limit   <= 16'd100;
      cfg_r.file_ident      <= 8'd0;
      cfg_r.info_message_id <= 8'd0;
      cfg_r.chunk_packet_id <= 8'd0;
      cfg_r.end_message_id  <= 8'd0;
      cfg_r.info_min_length <= 8'd9;
      cfg_r.max_chunk_bytes <= 8'd255;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_TIMEOUT_LIMIT:   prdata = {16'd0, cfg_r.timeout_limit};
      REG_FILE_IDENT:      prdata = {24'd0, cfg_r.file_ident};
      REG_INFO_MESSAGE_ID: prdata = {24'd0, cfg_r.info_message_id};
      REG_CHUNK_PACKET_ID: prdata = {24'd0, cfg_r.chunk_packet_id};
      REG_END_MESSAGE_ID:  prdata = {24'd0, cfg_r.end_message_id};
      REG_INFO_MIN_LENGTH: prdata = {24'd0, cfg_r.info_min_length};
      REG_MAX_CHUNK_BYTES: prdata = {24'd0, cfg_r.max_chunk_bytes};
      default:             prdata = '0;
    endcase
  end

endmodule

/* src/sawcr_front.sv */
module sawcr_front (
  sawcr_in_if.sink        in_ch,
  input  sawcr_pkg::cfg_t cfg,
  input  logic            q_ready,
  output logic            q_push,
  output sawcr_pkg::item_t q_item
);
  import sawcr_pkg::*;

  kind_t kind;

  assign kind        = kind_t'(in_ch.kind);
  assign in_ch.ready = q_ready;
  assign q_push      = in_ch.valid && q_ready;

  // Classify the poll against the configured ids and limits
  always_comb begin
    q_item.info_ok = (kind == KIND_MESSAGE) && (in_ch.msg_id == cfg.info_message_id) &&
                     (in_ch.msg_length >= cfg.info_min_length) &&
                     (in_ch.first_byte == cfg.file_ident);
    q_item.chunk_ok = (kind == KIND_CHUNK) && (in_ch.msg_id == cfg.chunk_packet_id) &&
                      (in_ch.msg_length != 8'd0) &&
                      (in_ch.msg_length <= cfg.max_chunk_bytes);
    q_item.end_ok = (kind == KIND_MESSAGE) && (in_ch.msg_id == cfg.end_message_id) &&
                    (in_ch.msg_length != 8'd0) &&
                    (in_ch.first_byte == cfg.end_message_id);
    q_item.msg_length   = in_ch.msg_length;
    q_item.word_one     = in_ch.word_one;
    q_item.word_two     = in_ch.word_two;
    q_item.packet_index = in_ch.packet_index;
    q_item.storage_ok   = in_ch.storage_ok;
  end

endmodule

/* src/sawcr_queue.sv */
module sawcr_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sawcr_pkg::item_t push_item,
  output logic             not_full,
  input  logic             pop,
  output sawcr_pkg::item_t head_item,
  output logic             not_empty
);
  import sawcr_pkg::*;

  item_t                    mem_r [QueueDepth];
  logic [QueuePtrWidth-1:0] wr_ptr_r;
  logic [QueuePtrWidth-1:0] rd_ptr_r;
  logic [QueueCntWidth-1:0] cnt_r;

  assign not_full  = (cnt_r != QueueCntWidth'(QueueDepth));
  assign not_empty = (cnt_r != '0);
  assign head_item = mem_r[rd_ptr_r];

  // Store entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QueuePtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QueuePtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

/* src/sawcr_back.sv */
module sawcr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  sawcr_pkg::cfg_t    cfg,
  input  sawcr_pkg::item_t   head_item,
  input  logic               head_valid,
  output logic               pop,
  output sawcr_pkg::result_t res,
  output logic               res_valid,
  input  logic               res_ready
);
  import sawcr_pkg::*;

  phase_t      phase_r, phase_nxt;
  phase_t      prior_r, prior_nxt;
  logic [15:0] miss_r, miss_nxt;
  logic [31:0] total_r, total_nxt;
  logic [31:0] size_r, size_nxt;
  logic [16:0] recv_r, recv_nxt;
  result_t     res_r, res_nxt;
  logic        res_valid_r;

  req_t        req;
  logic [15:0] cidx;
  logic [7:0]  clen;
  logic        ack, done, err;
  logic        miss;
  phase_t      miss_from;
  logic        miss_abort;

  assign pop       = head_valid && (!res_valid_r || res_ready);
  assign res       = res_r;
  assign res_valid = res_valid_r;
  assign miss_abort = (miss_r >= cfg.timeout_limit);

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    prior_nxt = prior_r;
    miss_nxt  = miss_r;
    total_nxt = total_r;
    size_nxt  = size_r;
    recv_nxt  = recv_r;
    miss      = 1'b0;
    miss_from = phase_r;
    case (phase_r)
      PH_IDLE: begin
        miss_nxt  = '0;
        total_nxt = '0;
        prior_nxt = PH_IDLE;
        if (head_item.storage_ok) begin
          recv_nxt  = '0;
          phase_nxt = PH_INFO;
        end else begin
          phase_nxt = PH_ERROR;
        end
      end
      PH_INFO: begin
        if (head_item.info_ok) begin
          size_nxt  = head_item.word_one;
          total_nxt = head_item.word_two;
          recv_nxt  = '0;
          miss_nxt  = '0;
          prior_nxt = PH_INFO;
          phase_nxt = head_item.storage_ok ? PH_ACK : PH_ERROR;
        end else begin
          miss = 1'b1;
        end
      end
      PH_CHUNK: begin
        if (head_item.chunk_ok && ({1'b0, head_item.packet_index} == recv_r) &&
            head_item.storage_ok) begin
          recv_nxt  = recv_r + 17'd1;
          miss_nxt  = '0;
          prior_nxt = PH_CHUNK;
          phase_nxt = PH_ACK;
        end else if (head_item.chunk_ok && ({1'b0, head_item.packet_index} < recv_r)) begin
          miss_nxt  = '0;
          prior_nxt = PH_CHUNK;
          phase_nxt = PH_ACK;
        end else begin
          miss = 1'b1;
        end
      end
      PH_ACK: begin
        if (prior_r == PH_INFO) begin
          prior_nxt = PH_ACK;
          phase_nxt = PH_CHUNK;
        end else if (prior_r == PH_CHUNK) begin
          prior_nxt = PH_ACK;
          phase_nxt = ({15'd0, recv_r} >= total_r) ? PH_COMPLETE : PH_CHUNK;
        end else if (prior_r == PH_COMPLETE) begin
          prior_nxt = PH_IDLE;
          phase_nxt = PH_IDLE;
        end else begin
          phase_nxt = PH_ERROR;
        end
      end
      PH_COMPLETE: begin
        if (head_item.end_ok) begin
          miss_nxt  = '0;
          prior_nxt = PH_COMPLETE;
          phase_nxt = PH_ACK;
        end else begin
          miss = 1'b1;
        end
      end
      PH_ERROR: begin
        miss_nxt  = '0;
        total_nxt = '0;
        prior_nxt = PH_IDLE;
        phase_nxt = PH_IDLE;
      end
      default: begin
        miss_nxt  = '0;
        prior_nxt = PH_IDLE;
        phase_nxt = PH_IDLE;
      end
    endcase
    // Count a miss, or abort once the limit is reached
    if (miss) begin
      if (miss_abort) begin
        miss_nxt  = '0;
        prior_nxt = miss_from;
        phase_nxt = PH_ERROR;
      end else begin
        miss_nxt = miss_r + 16'd1;
      end
    end
  end

  // Step outputs
  always_comb begin
    req  = RQ_NONE;
    cidx = '0;
    clen = '0;
    ack  = 1'b0;
    done = 1'b0;
    err  = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        req = RQ_CLEAR;
        err = !head_item.storage_ok;
      end
      PH_INFO: begin
        if (head_item.info_ok) begin
          req = RQ_OPEN;
          err = !head_item.storage_ok;
        end else begin
          err = miss_abort;
        end
      end
      PH_CHUNK: begin
        if (head_item.chunk_ok && ({1'b0, head_item.packet_index} == recv_r)) begin
          req  = RQ_WRITE;
          cidx = head_item.packet_index;
          clen = head_item.msg_length;
        end
        err = miss && miss_abort;
      end
      PH_ACK: begin
        ack  = 1'b1;
        done = (prior_r == PH_COMPLETE);
        err  = !(prior_r inside {PH_INFO, PH_CHUNK, PH_COMPLETE});
      end
      PH_COMPLETE: begin
        req = RQ_META;
        err = !head_item.end_ok && miss_abort;
      end
      PH_ERROR: begin
        req = RQ_CLOSE;
      end
      default: begin
        req = RQ_NONE;
      end
    endcase
  end

  // Assemble result
  always_comb begin
    res_nxt.phase          = phase_nxt;
    res_nxt.request        = req;
    res_nxt.chunk_index    = cidx;
    res_nxt.chunk_length   = clen;
    res_nxt.send_ack       = ack;
    res_nxt.transfer_done  = done;
    res_nxt.went_error     = err;
    res_nxt.chunk_size_out = size_nxt;
    res_nxt.received_count = recv_nxt;
    res_nxt.expected_total = total_nxt;
  end

  // Update state on each popped poll
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      prior_r <= PH_IDLE;
      miss_r  <= '0;
      total_r <= '0;
      size_r  <= '0;
      recv_r  <= '0;
    end else if (pop) begin
      phase_r <= phase_nxt;
      prior_r <= prior_nxt;
      miss_r  <= miss_nxt;
      total_r <= total_nxt;
      size_r  <= size_nxt;
      recv_r  <= recv_nxt;
    end
  end

  // Hold result until its transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (pop) begin
      res_valid_r <= 1'b1;
    end else if (res_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

endmodule

/* tb/sawcr_transfer_checker.sv */
module sawcr_transfer_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  sawcr_in_if                             in_ch,
  sawcr_out_if                            out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sawcr_pkg::AddrWidth-1:0] paddr,
  input  logic [sawcr_pkg::DataWidth-1:0] pwdata,
  input  logic                            pready,
  output int unsigned                     fail_count,
  output int unsigned                     pending,
  output logic [2:0]                      phase_now,
  output logic [16:0]                     count_now,
  output logic [31:0]                     total_now
);
  import sawcr_pkg::*;

  // Shadow copy of the register file and the receiver state
  cfg_t        regs;
  logic [2:0]  phase_q;
  logic [2:0]  prior_q;
  logic [15:0] miss_q;
  logic [31:0] total_q;
  logic [31:0] size_q;
  logic [16:0] count_q;

  result_t awaited_results[$];

  assign phase_now = phase_q;
  assign count_now = count_q;
  assign total_now = total_q;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] seen,
                             input logic [31:0] due);
    if (seen !== due)
      report_mismatch($sformatf("%s is %0h, expected %0h", name, seen, due));
  endtask

  // Advance the miss counter; abort the transfer once the limit is reached
  task automatic count_miss(input logic [2:0] from, output logic aborted);
    aborted = 1'b0;
    if (miss_q >= regs.timeout_limit) begin
      miss_q  = '0;
      prior_q = from;
      phase_q = PH_ERROR;
      aborted = 1'b1;
    end else begin
      miss_q = miss_q + 16'd1;
    end
  endtask

  // Step the shadow state by one accepted poll and build the expected result
  task automatic predict_poll_result(output result_t r);
    logic [1:0]  kind;
    logic [7:0]  id;
    logic [7:0]  len;
    logic [7:0]  b0;
    logic [15:0] pidx;
    logic        ok;
    logic        accepted;
    logic        aborted;
    kind     = in_ch.kind;
    id       = in_ch.msg_id;
    len      = in_ch.msg_length;
    b0       = in_ch.first_byte;
    pidx     = in_ch.packet_index;
    ok       = in_ch.storage_ok;
    accepted = 1'b0;
    aborted  = 1'b0;
    r        = '0;
    r.request = RQ_NONE;
    case (phase_q)
      PH_IDLE: begin
        miss_q    = '0;
        total_q   = '0;
        r.request = RQ_CLEAR;
        prior_q   = PH_IDLE;
        if (!ok) begin
          phase_q = PH_ERROR;
          aborted = 1'b1;
        end else begin
          count_q = '0;
          phase_q = PH_INFO;
        end
      end
      PH_INFO: begin
        if (kind == KIND_MESSAGE && id == regs.info_message_id &&
            len >= regs.info_min_length && b0 == regs.file_ident) begin
          size_q    = in_ch.word_one;
          total_q   = in_ch.word_two;
          count_q   = '0;
          miss_q    = '0;
          r.request = RQ_OPEN;
          prior_q   = PH_INFO;
          if (!ok) begin
            phase_q = PH_ERROR;
            aborted = 1'b1;
          end else begin
            phase_q = PH_ACK;
          end
        end else begin
          count_miss(PH_INFO, aborted);
        end
      end
      PH_CHUNK: begin
        if (kind == KIND_CHUNK && id == regs.chunk_packet_id && len != 8'd0 &&
            len <= regs.max_chunk_bytes) begin
          if ({1'b0, pidx} == count_q) begin
            r.request      = RQ_WRITE;
            r.chunk_index  = pidx;
            r.chunk_length = len;
            if (ok) begin
              count_q  = count_q + 17'd1;
              accepted = 1'b1;
            end
          end else if ({1'b0, pidx} < count_q) begin
            // duplicate: acknowledge again, write nothing
            accepted = 1'b1;
          end
        end
        if (accepted) begin
          miss_q  = '0;
          prior_q = PH_CHUNK;
          phase_q = PH_ACK;
        end else begin
          count_miss(PH_CHUNK, aborted);
        end
      end
      PH_ACK: begin
        r.send_ack = 1'b1;
        if (prior_q == PH_INFO) begin
          prior_q = PH_ACK;
          phase_q = PH_CHUNK;
        end else if (prior_q == PH_CHUNK) begin
          prior_q = PH_ACK;
          phase_q = ({15'd0, count_q} >= total_q) ? PH_COMPLETE : PH_CHUNK;
        end else if (prior_q == PH_COMPLETE) begin
          prior_q         = PH_IDLE;
          phase_q         = PH_IDLE;
          r.transfer_done = 1'b1;
        end else begin
          phase_q = PH_ERROR;
          aborted = 1'b1;
        end
      end
      PH_COMPLETE: begin
        r.request = RQ_META;
        if (kind == KIND_MESSAGE && id == regs.end_message_id && len >= 8'd1 &&
            b0 == regs.end_message_id) begin
          miss_q  = '0;
          prior_q = PH_COMPLETE;
          phase_q = PH_ACK;
        end else begin
          count_miss(PH_COMPLETE, aborted);
        end
      end
      PH_ERROR: begin
        r.request = RQ_CLOSE;
        miss_q    = '0;
        total_q   = '0;
        prior_q   = PH_IDLE;
        phase_q   = PH_IDLE;
      end
      default: begin
        miss_q  = '0;
        prior_q = PH_IDLE;
        phase_q = PH_IDLE;
      end
    endcase
    r.went_error     = aborted;
    r.phase          = phase_q;
    r.chunk_size_out = size_q;
    r.received_count = count_q;
    r.expected_total = total_q;
  endtask

  always @(posedge clk) begin : track
    result_t due;
    result_t fresh;
    if (!rst_n) begin
      regs.timeout_limit   = 16'd100;
      regs.file_ident      = 8'd0;
      regs.info_message_id = 8'd0;
      regs.chunk_packet_id = 8'd0;
      regs.end_message_id  = 8'd0;
      regs.info_min_length = 8'd9;
      regs.max_chunk_bytes = 8'd255;
      phase_q = PH_IDLE;
      prior_q = PH_IDLE;
      miss_q  = '0;
      total_q = '0;
      size_q  = '0;
      count_q = '0;
      awaited_results.delete();
    end else begin
      // Track register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_TIMEOUT_LIMIT:   regs.timeout_limit   = pwdata[15:0];
          REG_FILE_IDENT:      regs.file_ident      = pwdata[7:0];
          REG_INFO_MESSAGE_ID: regs.info_message_id = pwdata[7:0];
          REG_CHUNK_PACKET_ID: regs.chunk_packet_id = pwdata[7:0];
          REG_END_MESSAGE_ID:  regs.end_message_id  = pwdata[7:0];
          REG_INFO_MIN_LENGTH: regs.info_min_length = pwdata[7:0];
          REG_MAX_CHUNK_BYTES: regs.max_chunk_bytes = pwdata[7:0];
          default: ;
        endcase
      end
      // Compare the result transfer against the oldest expectation
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result arrived with nothing expected");
        end else begin
          due = awaited_results.pop_front();
          check_field("phase", out_ch.phase, due.phase);
          check_field("request", out_ch.request, due.request);
          check_field("chunk_index", out_ch.chunk_index, due.chunk_index);
          check_field("chunk_length", out_ch.chunk_length, due.chunk_length);
          check_field("send_ack", out_ch.send_ack, due.send_ack);
          check_field("transfer_done", out_ch.transfer_done, due.transfer_done);
          check_field("went_error", out_ch.went_error, due.went_error);
          check_field("chunk_size_out", out_ch.chunk_size_out, due.chunk_size_out);
          check_field("received_count", out_ch.received_count, due.received_count);
          check_field("expected_total", out_ch.expected_total, due.expected_total);
        end
      end
      // Predict on each poll transfer
      if (in_ch.valid && in_ch.ready) begin
        predict_poll_result(fresh);
        awaited_results.push_back(fresh);
      end
    end
    pending = awaited_results.size();
  end

endmodule

/* tb/tb_stop_and_wait_chunk_receiver.sv */
module tb_stop_and_wait_chunk_receiver;
  import sawcr_pkg::*;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  msg_id;
    logic [7:0]  msg_length;
    logic [7:0]  first_byte;
    logic [31:0] word_one;
    logic [31:0] word_two;
    logic [15:0] packet_index;
    logic        storage_ok;
  } poll_t;

  localparam int unsigned CycleLimit    = 500000;
  localparam int unsigned RandomPhases  = 8;
  localparam int unsigned PollsPerPhase = 235;
  localparam int unsigned LongHold      = 150;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [DataWidth-1:0] pwdata;
  logic [DataWidth-1:0] prdata;
  logic                 pready;

  sawcr_in_if  in_bus ();
  sawcr_out_if out_bus ();

  int unsigned fail_count;
  int unsigned pending;
  logic [2:0]  phase_now;
  logic [16:0] count_now;
  logic [31:0] total_now;

  cfg_t        cur_cfg;
  bit          src_fast;
  bit          sink_fast;
  int unsigned sink_hold;
  int unsigned cycles = 0;

  always #10 clk = ~clk;

  stop_and_wait_chunk_receiver dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  sawcr_transfer_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_bus),
    .out_ch     (out_bus),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending),
    .phase_now  (phase_now),
    .count_now  (count_now),
    .total_now  (total_now)
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: before each transfer stall for sink_hold if set, else for a random number of cycles unless sink_fast
  initial begin : result_sink
    int unsigned pause;
    out_bus.ready <= 1'b0;
    @(negedge clk iff rst_n);
    forever begin
      if (sink_hold != 0) begin
        pause     = sink_hold;
        sink_hold = 0;
      end else begin
        pause = sink_fast ? 0 : $urandom_range(0, 11);
      end
      if (pause != 0) begin
        out_bus.ready <= 1'b0;
        repeat (pause) @(negedge clk);
      end
      out_bus.ready <= 1'b1;
      @(posedge clk iff (out_bus.valid && out_bus.ready));
      @(negedge clk);
    end
  end

  function automatic poll_t build_poll(input kind_t k, input logic [7:0] id,
                                       input logic [7:0] len, input logic [7:0] b0,
                                       input logic [31:0] w1, input logic [31:0] w2,
                                       input logic [15:0] idx, input logic ok);
    poll_t p;
    p = '{k, id, len, b0, w1, w2, idx, ok};
    return p;
  endfunction

  function automatic poll_t noise_poll();
    poll_t p;
    p.kind         = kind_t'($urandom_range(0, 3));
    p.msg_id       = 8'($urandom);
    p.msg_length   = 8'($urandom);
    p.first_byte   = 8'($urandom);
    p.word_one     = $urandom;
    p.word_two     = $urandom;
    p.packet_index = 16'($urandom);
    p.storage_ok   = 1'($urandom_range(0, 1));
    return p;
  endfunction

  // Mostly short files; long ones only where the miss limit lets them time out soon
  function automatic logic [31:0] pick_total();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(0, 4);
    if (r < 92 || cur_cfg.timeout_limit > 200) return $urandom_range(5, 12);
    if (r < 97) return $urandom_range(25, 60);
    return $urandom;
  endfunction

  function automatic cfg_t phase_settings(input int ph);
    cfg_t c;
    case (ph)
      0: c = '{16'd6, 8'h5A, 8'h10, 8'h20, 8'h30, 8'd9, 8'd255};
      1: c = '{16'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'd0, 8'd1};
      2: c = '{16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd255, 8'd255};
      default: begin
        case ($urandom_range(0, 3))
          0: c.timeout_limit = 16'($urandom_range(0, 4));
          1: c.timeout_limit = 16'($urandom_range(5, 40));
          2: c.timeout_limit = 16'd100;
          default: c.timeout_limit = 16'($urandom);
        endcase
        c.file_ident      = 8'($urandom);
        c.info_message_id = 8'($urandom);
        c.chunk_packet_id = 8'($urandom);
        c.end_message_id  = 8'($urandom);
        c.info_min_length = ($urandom_range(0, 3) == 0) ? 8'($urandom) :
                                                          8'($urandom_range(0, 12));
        c.max_chunk_bytes = 8'($urandom_range(1, 255));
      end
    endcase
    return c;
  endfunction

  // Offer one poll after a random gap (none when src_fast) and hold it until the transfer
  task automatic send_poll(input poll_t p);
    int unsigned gap;
    gap = src_fast ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.kind         <= p.kind;
    in_bus.msg_id       <= p.msg_id;
    in_bus.msg_length   <= p.msg_length;
    in_bus.first_byte   <= p.first_byte;
    in_bus.word_one     <= p.word_one;
    in_bus.word_two     <= p.word_two;
    in_bus.packet_index <= p.packet_index;
    in_bus.storage_ok   <= p.storage_ok;
    @(posedge clk iff in_bus.ready);
    @(negedge clk);
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk iff pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_settings(input cfg_t c);
    drain_results();
    write_reg(REG_TIMEOUT_LIMIT, {16'd0, c.timeout_limit});
    write_reg(REG_FILE_IDENT, {24'd0, c.file_ident});
    write_reg(REG_INFO_MESSAGE_ID, {24'd0, c.info_message_id});
    write_reg(REG_CHUNK_PACKET_ID, {24'd0, c.chunk_packet_id});
    write_reg(REG_END_MESSAGE_ID, {24'd0, c.end_message_id});
    write_reg(REG_INFO_MIN_LENGTH, {24'd0, c.info_min_length});
    write_reg(REG_MAX_CHUNK_BYTES, {24'd0, c.max_chunk_bytes});
    cur_cfg = c;
  endtask

  // Shape the next poll after the phase the receiver is in
  task automatic make_poll(output poll_t p);
    int unsigned pick;
    logic [16:0] got;
    logic [31:0] total;
    logic [7:0]  lim;
    p     = noise_poll();
    pick  = $urandom_range(0, 99);
    got   = count_now;
    total = total_now;
    lim   = cur_cfg.max_chunk_bytes;
    case (phase_now)
      PH_IDLE, PH_ERROR: p.storage_ok = (pick >= 8);
      PH_INFO: begin
        p.kind       = KIND_MESSAGE;
        p.msg_id     = cur_cfg.info_message_id;
        p.msg_length = 8'($urandom_range(cur_cfg.info_min_length, 255));
        p.first_byte = cur_cfg.file_ident;
        p.word_two   = pick_total();
        p.storage_ok = ($urandom_range(0, 19) != 0);
        if (pick >= 90) p = noise_poll();
        else if (pick >= 86) p.msg_id ^= 8'($urandom_range(1, 255));
        else if (pick >= 82 && cur_cfg.info_min_length != 0)
          p.msg_length = 8'($urandom_range(0, cur_cfg.info_min_length - 1));
        else if (pick >= 78) p.first_byte ^= 8'($urandom_range(1, 255));
        else if (pick >= 75) p.kind = KIND_CHUNK;
      end
      PH_CHUNK: begin
        p.kind         = KIND_CHUNK;
        p.msg_id       = cur_cfg.chunk_packet_id;
        p.msg_length   = 8'($urandom_range(1, lim));
        p.packet_index = got[15:0];
        p.storage_ok   = ($urandom_range(0, 11) != 0);
        if (got >= 24 && total > 24) begin
          // abandon a long file so the miss limit ends it
          p.kind = KIND_NONE;
        end else if (pick >= 92) begin
          p = noise_poll();
        end else if (pick >= 84 && got != 0) begin
          p.packet_index = 16'($urandom_range(0, got - 1));
        end else if (pick >= 78 && got < 65535) begin
          p.packet_index = 16'($urandom_range(got + 1, 65535));
        end else if (pick >= 74) begin
          if (lim == 8'd255 || $urandom_range(0, 1) == 0) p.msg_length = 8'd0;
          else p.msg_length = 8'($urandom_range(lim + 1, 255));
        end else if (pick >= 71) begin
          p.msg_id ^= 8'($urandom_range(1, 255));
        end
      end
      PH_COMPLETE: begin
        if (pick < 75) begin
          p.kind       = KIND_MESSAGE;
          p.msg_id     = cur_cfg.end_message_id;
          p.msg_length = 8'($urandom_range(1, 255));
          p.first_byte = cur_cfg.end_message_id;
          if (pick >= 68) p.msg_length = 8'd0;
          else if (pick >= 62) p.first_byte ^= 8'($urandom_range(1, 255));
        end
      end
      default: ;
    endcase
  endtask

  initial begin : stimulus
    poll_t p;
    rst_n               <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    in_bus.valid        <= 1'b0;
    in_bus.kind         <= KIND_NONE;
    in_bus.msg_id       <= '0;
    in_bus.msg_length   <= '0;
    in_bus.first_byte   <= '0;
    in_bus.word_one     <= '0;
    in_bus.word_two     <= '0;
    in_bus.packet_index <= '0;
    in_bus.storage_ok   <= 1'b0;
    src_fast  = 1'b0;
    sink_fast = 1'b0;
    sink_hold = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: one full file, then a failed clear, a failed open and a short info
    apply_settings('{16'd100, 8'h5A, 8'h10, 8'h20, 8'h30, 8'd9, 8'd255});
    send_poll(build_poll(KIND_NONE, 8'h00, 8'h00, 8'h00, 32'h0, 32'h0, 16'h0, 1'b1));
    send_poll(build_poll(KIND_MESSAGE, 8'h10, 8'd9, 8'h5A, 32'hFFFF_FFFF, 32'd2, 16'h0,
                         1'b1));
    send_poll(build_poll(KIND_NONE, 8'hFF, 8'hFF, 8'hFF, 32'h0, 32'h0, 16'hFFFF, 1'b0));
    send_poll(build_poll(KIND_CHUNK, 8'h20, 8'd255, 8'h00, 32'h0, 32'h0, 16'd0, 1'b1));
    send_poll(build_poll(KIND_NONE, 8'h00, 8'h00, 8'h00, 32'h0, 32'h0, 16'h0, 1'b1));
    // duplicate of chunk zero
    send_poll(build_poll(KIND_CHUNK, 8'h20, 8'd1, 8'h00, 32'h0, 32'h0, 16'd0, 1'b1));
    send_poll(build_poll(KIND_NONE, 8'h00, 8'h00, 8'h00, 32'h0, 32'h0, 16'h0, 1'b0));
    // gap, zero length and a failed write all count as misses
    send_poll(build_poll(KIND_CHUNK, 8'h20, 8'd4, 8'h00, 32'h0, 32'h0, 16'hFFFF, 1'b1));
    send_poll(build_poll(KIND_CHUNK, 8'h20, 8'd0, 8'h00, 32'h0, 32'h0, 16'd1, 1'b1));
    send_poll(build_poll(KIND_CHUNK, 8'h20, 8'd7, 8'h00, 32'h0, 32'h0, 16'd1, 1'b0));
    send_poll(build_poll(KIND_CHUNK, 8'h20, 8'd7, 8'h00, 32'h0, 32'h0, 16'd1, 1'b1));
    send_poll(build_poll(KIND_NONE, 8'h00, 8'h00, 8'h00, 32'h0, 32'h0, 16'h0, 1'b1));
    // complete: noise, short end message, then a good one
    send_poll(build_poll(KIND_OTHER, 8'h30, 8'd1, 8'h30, 32'h0, 32'hFFFF_FFFF, 16'h0,
                         1'b0));
    send_poll(build_poll(KIND_MESSAGE, 8'h30, 8'd0, 8'h30, 32'h0, 32'h0, 16'h0, 1'b1));
    send_poll(build_poll(KIND_MESSAGE, 8'h30, 8'd1, 8'h30, 32'h0, 32'h0, 16'h0, 1'b1));
    send_poll(build_poll(KIND_NONE, 8'h00, 8'h00, 8'h00, 32'h0, 32'h0, 16'h0, 1'b1));
    // failed clear, then failed open
    send_poll(build_poll(KIND_NONE, 8'h00, 8'h00, 8'h00, 32'h0, 32'h0, 16'h0, 1'b0));
    send_poll(build_poll(KIND_NONE, 8'h00, 8'h00, 8'h00, 32'h0, 32'h0, 16'h0, 1'b1));
    send_poll(build_poll(KIND_NONE, 8'h00, 8'h00, 8'h00, 32'h0, 32'h0, 16'h0, 1'b1));
    send_poll(build_poll(KIND_MESSAGE, 8'h10, 8'd255, 8'h5A, 32'd64, 32'd3, 16'h0, 1'b0));
    send_poll(build_poll(KIND_NONE, 8'h00, 8'h00, 8'h00, 32'h0, 32'h0, 16'h0, 1'b1));
    send_poll(build_poll(KIND_NONE, 8'h00, 8'h00, 8'h00, 32'h0, 32'h0, 16'h0, 1'b1));
    // info one byte too short
    send_poll(build_poll(KIND_MESSAGE, 8'h10, 8'd8, 8'h5A, 32'd64, 32'd3, 16'h0, 1'b1));

    // Random files under several register settings
    for (int ph = 0; ph < RandomPhases; ph++) begin
      apply_settings(phase_settings(ph));
      src_fast  = (ph % 3 == 1);
      sink_fast = (ph % 3 == 2);
      for (int n = 0; n < PollsPerPhase; n++) begin
        if (ph == 4 && n == 20) sink_hold = LongHold;
        if (ph == 6 && n == 100) drain_results();
        make_poll(p);
        send_poll(p);
      end
    end

    in_bus.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (5) @(negedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
